// ===== design/chtrk_pkg.sv =====
`timescale 1ns / 1ps

package chtrk_pkg;

    // Angles are radians scaled by 2^12; pi rounded to nearest in those units
    localparam logic signed [17:0] PI_Q     = 18'sd12868;
    localparam logic signed [17:0] TWO_PI_Q = 18'sd25736;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_DEADBAND      = 3'd0;
    localparam logic [2:0] REG_TRACK_STEP    = 3'd1;
    localparam logic [2:0] REG_SEARCH_STEP   = 3'd2;
    localparam logic [2:0] REG_CAM_GAIN      = 3'd3;
    localparam logic [2:0] REG_TIMEOUT_TICKS = 3'd4;
    localparam logic [2:0] REG_USE_RATE_MODE = 3'd5;

    // Reset values of the configuration registers
    localparam logic [9:0]         DEADBAND_RST      = 10'd100;
    localparam logic [13:0]        TRACK_STEP_RST    = 14'd45;
    localparam logic signed [14:0] SEARCH_STEP_RST   = 15'sd89;
    localparam logic [19:0]        CAM_GAIN_RST      = 20'd105414;
    localparam logic [15:0]        TIMEOUT_TICKS_RST = 16'd48;

    // Tick counter starts saturated so the block searches until the first face
    localparam logic [15:0] TICKS_RST = 16'hFFFF;

    // Rounding offset for the Q16 camera gain product
    localparam logic signed [31:0] Q16_HALF = 32'sd32768;

    typedef struct packed {
        logic [9:0]         deadband;
        logic [13:0]        track_step;
        logic signed [14:0] search_step;
        logic [19:0]        cam_gain;
        logic [15:0]        timeout_ticks;
        logic               use_rate_mode;
    } cfg_t;

    typedef struct packed {
        logic               kind;
        logic signed [10:0] lateral_offset;
        logic signed [14:0] current_yaw;
    } item_t;

    typedef struct packed {
        logic signed [14:0] heading_setpoint;
        logic               searching;
    } result_t;

    // Wrap an angle to [-pi, pi]; input magnitude stays below four pi.
    // Both +pi and -pi are kept as they are.
    function automatic logic signed [14:0] wrap_angle(input logic signed [17:0] v);
        logic signed [17:0] r;
        r = v;
        if (r >= TWO_PI_Q)
        begin
            r = r - TWO_PI_Q;
        end
        else if (r <= -TWO_PI_Q)
        begin
            r = r + TWO_PI_Q;
        end
        if (r > PI_Q)
        begin
            r = r - TWO_PI_Q;
        end
        else if (r < -PI_Q)
        begin
            r = r + TWO_PI_Q;
        end
        return r[14:0];
    endfunction

endpackage

// ===== design/camera_heading_tracker_unit.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Payload
// s_axis    in         tdata: lateral_offset[10:0], current_yaw[25:11]; tuser: kind
// m_axis    out        tdata: heading_setpoint[14:0], searching[15]
// cfg       in         cfg_index selects register, cfg_data holds the value
//
// One request per cycle sustained while m_axis accepts; each request is registered, then
// computed combinationally (gain multiply, wrap, clamp, wrap) into the result register.
// Reset clears heading, offset and valid flags and starts the block in search.
// While m_axis stalls the result register holds and one request waits in the
// input register; s_axis_tready drops only when both are full.

module camera_heading_tracker_unit
    import chtrk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // lateral_offset[10:0], current_yaw[25:11], zero fill
    input  logic        s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // heading_setpoint[14:0], searching[15]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    logic    out_valid_reg;
    result_t out_reg;
    result_t result;
    logic    out_free;
    logic    fire;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    chtrk_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    chtrk_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (item_reg),
        .fire   (fire),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            item_reg.kind           <= s_axis_tuser;
            item_reg.lateral_offset <= $signed(s_axis_tdata[10:0]);
            item_reg.current_yaw    <= $signed(s_axis_tdata[25:11]);
        end
        if (fire)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.searching, out_reg.heading_setpoint};

endmodule

// ===== design/chtrk_cfg.sv =====
`timescale 1ns / 1ps

module chtrk_cfg
    import chtrk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEADBAND:      cfg_next.deadband      = cfg_data[9:0];
                REG_TRACK_STEP:    cfg_next.track_step    = cfg_data[13:0];
                REG_SEARCH_STEP:   cfg_next.search_step   = $signed(cfg_data[14:0]);
                REG_CAM_GAIN:      cfg_next.cam_gain      = cfg_data;
                REG_TIMEOUT_TICKS: cfg_next.timeout_ticks = cfg_data[15:0];
                REG_USE_RATE_MODE: cfg_next.use_rate_mode = cfg_data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.deadband      <= DEADBAND_RST;
            cfg_reg.track_step    <= TRACK_STEP_RST;
            cfg_reg.search_step   <= SEARCH_STEP_RST;
            cfg_reg.cam_gain      <= CAM_GAIN_RST;
            cfg_reg.timeout_ticks <= TIMEOUT_TICKS_RST;
            cfg_reg.use_rate_mode <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/chtrk_core.sv =====
`timescale 1ns / 1ps

module chtrk_core
    import chtrk_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  item_t   item,
    input  logic    fire,
    output result_t result
);

    logic signed [14:0] heading_reg;
    logic signed [14:0] heading_next;
    logic [15:0]        ticks_reg;
    logic [15:0]        ticks_next;
    logic signed [10:0] face_offset_reg;
    logic signed [10:0] face_offset_next;

    logic signed [31:0] cam_prod;
    logic signed [31:0] cam_rnd;
    logic signed [17:0] cam_angle;
    logic signed [17:0] target_diff;
    logic signed [17:0] diff_wrapped;
    logic signed [17:0] lim;
    logic signed [17:0] track_clamped;
    logic signed [11:0] offset_ext;
    logic signed [11:0] deadband_ext;
    logic signed [17:0] step;
    logic               tracking;
    logic               searching;

    always_comb
    begin
        // camera angle: round(gain * offset / 2^16), ties toward plus infinity
        cam_prod  = $signed({1'b0, cfg.cam_gain}) * face_offset_reg;
        cam_rnd   = cam_prod + Q16_HALF;
        cam_angle = {{2{cam_rnd[31]}}, cam_rnd[31:16]};

        target_diff  = {{3{item.current_yaw[14]}}, item.current_yaw} + cam_angle
                       - {{3{heading_reg[14]}}, heading_reg};
        diff_wrapped = 18'(wrap_angle(target_diff));

        lim = {4'd0, cfg.track_step};
        priority if (diff_wrapped > lim)
        begin
            track_clamped = lim;
        end
        else if (diff_wrapped < -lim)
        begin
            track_clamped = -lim;
        end
        else
        begin
            track_clamped = diff_wrapped;
        end

        offset_ext   = {face_offset_reg[10], face_offset_reg};
        deadband_ext = {2'd0, cfg.deadband};

        tracking = (ticks_reg < cfg.timeout_ticks);

        priority if (!tracking)
        begin
            step = {{3{cfg.search_step[14]}}, cfg.search_step};
        end
        else if (!cfg.use_rate_mode)
        begin
            step = track_clamped;
        end
        else if (offset_ext > deadband_ext)
        begin
            step = lim;
        end
        else if (offset_ext < -deadband_ext)
        begin
            step = -lim;
        end
        else
        begin
            step = 18'sd0;
        end

        heading_next     = heading_reg;
        ticks_next       = ticks_reg;
        face_offset_next = face_offset_reg;
        if (item.kind)
        begin
            // detection: latch the face offset, hold heading, restart the timeout
            face_offset_next = item.lateral_offset;
            ticks_next       = 16'd0;
            searching        = (cfg.timeout_ticks == 16'd0);
        end
        else
        begin
            heading_next = wrap_angle({{3{heading_reg[14]}}, heading_reg} + step);
            if (tracking)
            begin
                ticks_next = ticks_reg + 16'd1;
            end
            searching = !tracking;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heading_reg     <= 15'sd0;
            ticks_reg       <= TICKS_RST;
            face_offset_reg <= 11'sd0;
        end
        else if (fire)
        begin
            heading_reg     <= heading_next;
            ticks_reg       <= ticks_next;
            face_offset_reg <= face_offset_next;
        end
    end

    assign result.heading_setpoint = heading_next;
    assign result.searching        = searching;

endmodule
